@@ hw/rtl/srsw_pkg.sv @@
package srsw_pkg;

  // Field widths fixed by the interface.
  localparam int POS_W   = 8;
  localparam int FRAME_W = 7;
  localparam int CNT_W   = 32;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FRAME_COUNT = 1'b0;
  localparam cfg_idx_t CFG_WINDOW_SIZE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RETRY,
    S_SLIDE,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // record the transaction and update counters and flags
    logic ptr_next;   // pointer to the frame after the current one
    logic ptr_base;   // pointer to the window base
    logic ptr_inc;    // step the pointer by one frame
    logic take_ptr;   // the pointer becomes the next scheduled frame
    logic set_retry;  // enter the retransmit pass
    logic new_round;  // base moves to the pointer and a new round begins
    logic load_out;   // capture the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;        // every frame acknowledged
    logic retry;       // retransmit pass active
    logic ptr_lt_rend; // pointer inside the current round
    logic ptr_lt_n;    // pointer below the frame count
    logic flag_at_ptr; // frame at the pointer is acknowledged
  } status_t;

  // Result of one transaction.
  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               is_retransmit;
    logic               frame_acked;
    logic [POS_W-1:0]   window_base;
    logic               all_done;
    logic               no_transmission;
    logic [CNT_W-1:0]   transmit_count;
    logic [CNT_W-1:0]   retransmit_count;
  } result_t;

endpackage

@@ hw/rtl/srsw_if.sv @@
// Input channel: one channel outcome per transaction.
interface srsw_in_if;
  logic valid;
  logic ready;
  logic lost;

  modport source (output valid, output lost, input ready);
  modport sink (input valid, input lost, output ready);
endinterface

// Output channel: one transmission report per transaction.
interface srsw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  frame_index;
  logic        is_retransmit;
  logic        frame_acked;
  logic [7:0]  window_base;
  logic        all_done;
  logic        no_transmission;
  logic [31:0] transmit_count;
  logic [31:0] retransmit_count;

  modport source (
    output valid, output frame_index, output is_retransmit, output frame_acked,
    output window_base, output all_done, output no_transmission,
    output transmit_count, output retransmit_count, input ready
  );
  modport sink (
    input valid, input frame_index, input is_retransmit, input frame_acked,
    input window_base, input all_done, input no_transmission,
    input transmit_count, input retransmit_count, output ready
  );
endinterface

@@ hw/rtl/selective_repeat_sender_window_unit.sv @@
// An accepted outcome goes from S_IDLE to S_SCAN, which steps over acknowledged frames; where the
// scan runs off the end of the round, S_RETRY and then S_SLIDE (or S_SLIDE alone in a retransmit
// pass) follow, and S_FINISH loads the result. An outcome after completion goes straight to S_FINISH.
// A new outcome is taken only in S_IDLE, once the last result is in the output register; the next
// outcome is taken while a result waits in the output register.
// Reset (rst, synchronous): registers to frame_count 0 and window_size 1, window cleared.
module selective_repeat_sender_window_unit #(
  parameter int MAX_FRAMES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  srsw_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]         cfg_data,
  srsw_in_if.sink            in_ch,
  srsw_out_if.source         out_ch
);
  import srsw_pkg::*;

  cmd_t    cmd;
  status_t st;
  result_t result;

  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  srsw_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lost      (in_ch.lost),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

  // Result fields onto the output channel.
  assign out_ch.frame_index      = result.frame_index;
  assign out_ch.is_retransmit    = result.is_retransmit;
  assign out_ch.frame_acked      = result.frame_acked;
  assign out_ch.window_base      = result.window_base;
  assign out_ch.all_done         = result.all_done;
  assign out_ch.no_transmission  = result.no_transmission;
  assign out_ch.transmit_count   = result.transmit_count;
  assign out_ch.retransmit_count = result.retransmit_count;

endmodule

@@ hw/rtl/srsw_ctrl.sv @@
module srsw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  srsw_pkg::status_t st,
  output srsw_pkg::cmd_t   cmd
);
  import srsw_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.done) begin
            state_next = S_FINISH;
          end else begin
            cmd.ptr_next = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end

      // Look for the next unacknowledged frame in the rest of the round.
      S_SCAN: begin
        if (!st.ptr_lt_rend) begin
          cmd.ptr_base = 1'b1;
          state_next   = st.retry ? S_SLIDE : S_RETRY;
        end else if (!st.flag_at_ptr) begin
          cmd.take_ptr = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end

      // Look for a frame still missing from the start of the window.
      S_RETRY: begin
        if (!st.ptr_lt_rend) begin
          cmd.ptr_base = 1'b1;
          state_next   = S_SLIDE;
        end else if (!st.flag_at_ptr) begin
          cmd.take_ptr  = 1'b1;
          cmd.set_retry = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end

      // Slide the base past acknowledged frames, then open a new round.
      S_SLIDE: begin
        if (st.ptr_lt_n && st.flag_at_ptr) begin
          cmd.ptr_inc = 1'b1;
        end else begin
          cmd.new_round = 1'b1;
          state_next    = S_FINISH;
        end
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/srsw_dp.sv @@
module srsw_dp #(
  parameter int MAX_FRAMES = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  srsw_pkg::cfg_idx_t    cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  lost,
  input  srsw_pkg::cmd_t        cmd,
  output srsw_pkg::status_t     st,
  output srsw_pkg::result_t     result
);
  import srsw_pkg::*;

  // Frame numbers never reach 255 because the frame count is eight bits wide.
  localparam int CAP   = (MAX_FRAMES > 255) ? 255 : MAX_FRAMES;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAP);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [POS_W-1:0] frame_count;
  logic [POS_W-1:0] window_size;
  logic [POS_W-1:0] fc_new;
  logic [POS_W-1:0] ws_new;
  logic [POS_W-1:0] n_cur;
  logic [POS_W-1:0] w_cur;

  logic [CAP-1:0]   acked;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] rend;
  logic [POS_W-1:0] scan;
  logic [POS_W-1:0] ptr;
  logic             retry;
  logic [CNT_W-1:0] tx;
  logic [CNT_W-1:0] retx;

  logic [FRAME_W-1:0] rec_frame;
  logic               rec_retx;
  logic               rec_acked;
  logic               rec_idle;
  logic               done;

  function automatic logic [POS_W-1:0] eff_frames(input logic [POS_W-1:0] fc);
    return (fc > CAP_POS) ? CAP_POS : fc;
  endfunction

  function automatic logic [POS_W-1:0] eff_window(input logic [POS_W-1:0] ws);
    return (ws == '0) ? POS_W'(1) : ws;
  endfunction

  // End of a round: the smaller of base plus window and the frame count.
  function automatic logic [POS_W-1:0] round_end(input logic [POS_W-1:0] b,
                                                 input logic [POS_W-1:0] w,
                                                 input logic [POS_W-1:0] n);
    logic [POS_W:0] sum;
    sum = {1'b0, b} + {1'b0, w};
    return (sum > {1'b0, n}) ? n : sum[POS_W-1:0];
  endfunction

  // Register values as they stand after a write in this cycle.
  assign fc_new = (cfg_we && cfg_index == CFG_FRAME_COUNT) ? cfg_data : frame_count;
  assign ws_new = (cfg_we && cfg_index == CFG_WINDOW_SIZE) ? cfg_data : window_size;
  assign n_cur  = eff_frames(frame_count);
  assign w_cur  = eff_window(window_size);
  assign done   = (base >= n_cur);

  // Status for the sequencer.
  always_comb begin
    st.done        = done;
    st.retry       = retry;
    st.ptr_lt_rend = (ptr < rend);
    st.ptr_lt_n    = (ptr < n_cur);
    st.flag_at_ptr = st.ptr_lt_n && acked[ptr[IDX_W-1:0]];
  end

  // Window state, acknowledge flags and counters. A register write restarts
  // the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      window_size <= POS_W'(1);
      acked       <= '0;
      base        <= '0;
      rend        <= '0;
      scan        <= '0;
      ptr         <= '0;
      retry       <= 1'b0;
      tx          <= '0;
      retx        <= '0;
    end else if (cfg_we) begin
      frame_count <= fc_new;
      window_size <= ws_new;
      acked       <= '0;
      base        <= '0;
      rend        <= round_end('0, eff_window(ws_new), eff_frames(fc_new));
      scan        <= '0;
      retry       <= 1'b0;
      tx          <= '0;
      retx        <= '0;
    end else begin
      if (cmd.accept && !done) begin
        if (tx != CNT_MAX) begin
          tx <= tx + CNT_W'(1);
        end
        if (retry && retx != CNT_MAX) begin
          retx <= retx + CNT_W'(1);
        end
        if (!lost) begin
          acked[scan[IDX_W-1:0]] <= 1'b1;
        end
      end

      if (cmd.ptr_next) begin
        ptr <= scan + POS_W'(1);
      end else if (cmd.ptr_base) begin
        ptr <= base;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + POS_W'(1);
      end

      if (cmd.take_ptr) begin
        scan <= ptr;
      end
      if (cmd.set_retry) begin
        retry <= 1'b1;
      end

      if (cmd.new_round) begin
        base  <= ptr;
        rend  <= round_end(ptr, w_cur, n_cur);
        scan  <= ptr;
        retry <= 1'b0;
      end
    end
  end

  // Details of the accepted transaction and the output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rec_idle  <= done;
      rec_frame <= done ? '0 : scan[FRAME_W-1:0];
      rec_retx  <= !done && retry;
      rec_acked <= !done && !lost;
    end
    if (cmd.load_out) begin
      result.frame_index      <= rec_frame;
      result.is_retransmit    <= rec_retx;
      result.frame_acked      <= rec_acked;
      result.window_base      <= base;
      result.all_done         <= done;
      result.no_transmission  <= rec_idle;
      result.transmit_count   <= tx;
      result.retransmit_count <= retx;
    end
  end

endmodule
